// ===== src/pdtt_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pdtt_pkg
// Shared constants, status codes and controller/datapath handshake types for
// the periodic deadline timer table.
// ----------------------------------------------------------------------------
package pdtt_pkg;

   localparam int TIMER_COUNT   = 8;
   localparam int ADDR_W        = (TIMER_COUNT > 1) ? $clog2(TIMER_COUNT) : 1;
   localparam logic [8:0] TIMER_COUNT_W = 9'(TIMER_COUNT);

   localparam logic [15:0] CATCHUP_LIMIT = 16'd65535;

   localparam logic [29:0] NS_PER_SEC     = 30'd1000000000;
   localparam logic [30:0] NS_PER_SEC_X1  = 31'd1000000000;
   localparam logic [30:0] NS_PER_SEC_X2  = 31'd2000000000;

   // table entry: {period, nanoseconds, seconds}
   localparam int ENTRY_W = 30 + 30 + 32;

   localparam logic CMD_INIT    = 1'b0;
   localparam logic CMD_FORWARD = 1'b1;

   localparam logic [1:0] ST_OK         = 2'd0;
   localparam logic [1:0] ST_BAD_INDEX  = 2'd1;
   localparam logic [1:0] ST_ZERO_PER   = 2'd2;
   localparam logic [1:0] ST_CATCHUP    = 2'd3;

   typedef struct packed {
      logic capture;
      logic decide;
      logic load;
      logic step;
      logic done;
   } ctl_type;

   typedef struct packed {
      logic bad_index;
      logic is_forward;
      logic zero_period;
      logic keep_going;
      logic out_free;
   } sts_type;

endpackage

// ===== src/pdtt_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pdtt_ram
// Generic single write port, single read port RAM with registered read data.
// ----------------------------------------------------------------------------
module pdtt_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 8
) (
   input  logic                                     clock,
   input  logic                                     wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                         wr_data,
   input  logic                                     rd_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== src/pdtt_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pdtt_ctrl
// Sequencer for one command: capture, decode, table read, catch-up loop and
// result hand-off to the output register.
// ----------------------------------------------------------------------------
module pdtt_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_tvalid,
   output logic             req_tready,
   input  pdtt_pkg::sts_type sts,
   output pdtt_pkg::ctl_type ctl
);

   localparam logic [2:0] S_IDLE   = 3'd0;
   localparam logic [2:0] S_DECODE = 3'd1;
   localparam logic [2:0] S_LOAD   = 3'd2;
   localparam logic [2:0] S_STEP   = 3'd3;
   localparam logic [2:0] S_DONE   = 3'd4;

   logic [2:0] state_ff;
   logic [2:0] state_in;

   always_comb begin
      state_in    = state_ff;
      ctl         = '0;
      req_tready  = 1'b0;
      case (state_ff)
         S_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               ctl.capture = 1'b1;
               state_in    = S_DECODE;
            end
         end
         S_DECODE: begin
            ctl.decide = 1'b1;
            if (sts.bad_index || !sts.is_forward) begin
               state_in = S_DONE;
            end else begin
               state_in = S_LOAD;
            end
         end
         S_LOAD: begin
            ctl.load = 1'b1;
            state_in = sts.zero_period ? S_DONE : S_STEP;
         end
         S_STEP: begin
            ctl.step = 1'b1;
            if (!sts.keep_going) begin
               state_in = S_DONE;
            end
         end
         S_DONE: begin
            if (sts.out_free) begin
               ctl.done = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// ===== src/pdtt_datapath.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pdtt_datapath
// Command registers, timer table with per-entry valid bits, deadline
// advance unit and the result output register.
// ----------------------------------------------------------------------------
module pdtt_datapath (
   input  logic              clock,
   input  logic              reset,
   input  logic [103:0]      req_tdata,
   output logic              rsp_tvalid,
   input  logic              rsp_tready,
   output logic [79:0]       rsp_tdata,
   input  pdtt_pkg::ctl_type ctl,
   output pdtt_pkg::sts_type sts
);

   // captured command
   logic                       cmd_ff, cmd_in;
   logic [7:0]                 idx_ff, idx_in;
   logic [29:0]                per_in_ff, per_in_in;
   logic [31:0]                now_s_ff, now_s_in;
   logic [29:0]                now_n_ff, now_n_in;
   // working deadline and period
   logic [31:0]                d_s_ff, d_s_in;
   logic [29:0]                d_n_ff, d_n_in;
   logic [29:0]                p_ff, p_in;
   logic [15:0]                count_ff, count_in;
   logic [1:0]                 status_ff, status_in;
   logic                       wr_ff, wr_in;
   logic [pdtt_pkg::TIMER_COUNT-1:0] valid_ff, valid_in;
   logic                       rsp_valid_ff, rsp_valid_in;
   logic [79:0]                rsp_data_ff, rsp_data_in;

   logic [pdtt_pkg::ADDR_W-1:0] addr;
   logic [pdtt_pkg::ENTRY_W-1:0] rd_data;
   logic [pdtt_pkg::ENTRY_W-1:0] wr_data;
   logic                        ram_we;
   logic                        entry_valid;
   logic [31:0]                 ent_s;
   logic [29:0]                 ent_n;
   logic [29:0]                 ent_p;
   logic                        now_after;
   logic [30:0]                 sum_n;
   logic [31:0]                 adv_s;
   logic [29:0]                 adv_n;
   logic [29:0]                 req_nsec;
   logic [31:0]                 req_sec;

   assign addr        = idx_ff[pdtt_pkg::ADDR_W-1:0];
   assign entry_valid = valid_ff[addr];
   assign ent_s       = entry_valid ? rd_data[31:0]  : 32'd0;
   assign ent_n       = entry_valid ? rd_data[61:32] : 30'd0;
   assign ent_p       = entry_valid ? rd_data[91:62] : 30'd0;
   assign wr_data     = {p_ff, d_n_ff, d_s_ff};
   assign ram_we      = ctl.done && wr_ff;

   assign req_nsec = req_tdata[100:71];
   assign req_sec  = req_tdata[70:39];

   // current time at or after the deadline
   assign now_after = (now_s_ff != d_s_ff) ? (now_s_ff > d_s_ff) : (now_n_ff >= d_n_ff);

   // one period addition with nanosecond carry, the sum stays below three seconds
   always_comb begin
      sum_n = {1'b0, d_n_ff} + {1'b0, p_ff};
      if (sum_n >= pdtt_pkg::NS_PER_SEC_X2) begin
         adv_n = 30'(sum_n - pdtt_pkg::NS_PER_SEC_X2);
         adv_s = d_s_ff + 32'd2;
      end else if (sum_n >= pdtt_pkg::NS_PER_SEC_X1) begin
         adv_n = 30'(sum_n - pdtt_pkg::NS_PER_SEC_X1);
         adv_s = d_s_ff + 32'd1;
      end else begin
         adv_n = sum_n[29:0];
         adv_s = d_s_ff;
      end
   end

   assign sts.bad_index   = {1'b0, idx_ff} >= pdtt_pkg::TIMER_COUNT_W;
   assign sts.is_forward  = cmd_ff == pdtt_pkg::CMD_FORWARD;
   assign sts.zero_period = ent_p == 30'd0;
   assign sts.keep_going  = (count_ff < pdtt_pkg::CATCHUP_LIMIT) && now_after;
   assign sts.out_free    = !rsp_valid_ff || rsp_tready;

   always_comb begin
      cmd_in       = cmd_ff;
      idx_in       = idx_ff;
      per_in_in    = per_in_ff;
      now_s_in     = now_s_ff;
      now_n_in     = now_n_ff;
      d_s_in       = d_s_ff;
      d_n_in       = d_n_ff;
      p_in         = p_ff;
      count_in     = count_ff;
      status_in    = status_ff;
      wr_in        = wr_ff;
      valid_in     = valid_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;

      if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end

      if (ctl.capture) begin
         cmd_in    = req_tdata[0];
         idx_in    = req_tdata[8:1];
         per_in_in = req_tdata[38:9];
         // fold an out of range nanosecond value into the seconds
         if (req_nsec >= pdtt_pkg::NS_PER_SEC) begin
            now_n_in = req_nsec - pdtt_pkg::NS_PER_SEC;
            now_s_in = req_sec + 32'd1;
         end else begin
            now_n_in = req_nsec;
            now_s_in = req_sec;
         end
      end

      if (ctl.decide) begin
         count_in  = 16'd0;
         status_in = pdtt_pkg::ST_OK;
         wr_in     = 1'b0;
         if (sts.bad_index) begin
            status_in = pdtt_pkg::ST_BAD_INDEX;
            d_s_in    = 32'd0;
            d_n_in    = 30'd0;
         end else if (!sts.is_forward) begin
            d_s_in = now_s_ff;
            d_n_in = now_n_ff;
            p_in   = per_in_ff;
            wr_in  = 1'b1;
         end
      end

      if (ctl.load) begin
         d_s_in    = ent_s;
         d_n_in    = ent_n;
         p_in      = ent_p;
         status_in = sts.zero_period ? pdtt_pkg::ST_ZERO_PER : pdtt_pkg::ST_OK;
         wr_in     = !sts.zero_period;
      end

      if (ctl.step) begin
         if (sts.keep_going) begin
            d_s_in   = adv_s;
            d_n_in   = adv_n;
            count_in = count_ff + 16'd1;
         end else begin
            status_in = now_after ? pdtt_pkg::ST_CATCHUP : pdtt_pkg::ST_OK;
         end
      end

      if (ctl.done) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = {d_n_ff, d_s_ff, count_ff, status_ff};
         if (wr_ff) begin
            valid_in[addr] = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         valid_ff     <= valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      cmd_ff      <= cmd_in;
      idx_ff      <= idx_in;
      per_in_ff   <= per_in_in;
      now_s_ff    <= now_s_in;
      now_n_ff    <= now_n_in;
      d_s_ff      <= d_s_in;
      d_n_ff      <= d_n_in;
      p_ff        <= p_in;
      count_ff    <= count_in;
      status_ff   <= status_in;
      wr_ff       <= wr_in;
      rsp_data_ff <= rsp_data_in;
   end

   pdtt_ram #(
      .WIDTH (pdtt_pkg::ENTRY_W),
      .DEPTH (pdtt_pkg::TIMER_COUNT)
   ) u_table (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (addr),
      .wr_data (wr_data),
      .rd_en   (ctl.decide),
      .rd_addr (addr),
      .rd_data (rd_data)
   );

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   // a bad index result carries no deadline and no count
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_data_ff[1:0] == pdtt_pkg::ST_BAD_INDEX)
      |-> (rsp_data_ff[79:2] == '0))
      else $error("bad index result with nonzero payload");

   // catch-up status only after the full number of additions
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_data_ff[1:0] == pdtt_pkg::ST_CATCHUP)
      |-> (rsp_data_ff[17:2] == pdtt_pkg::CATCHUP_LIMIT))
      else $error("catch-up status with short count");

   // the deadline stays normalized through the catch-up loop
   assert property (@(posedge clock) disable iff (reset)
      ctl.step |-> (d_n_ff < pdtt_pkg::NS_PER_SEC))
      else $error("deadline nanoseconds out of range");

   // a result is never loaded over one still waiting
   assert property (@(posedge clock) disable iff (reset)
      ctl.done |-> (!rsp_valid_ff || rsp_tready))
      else $error("result overwritten while stalled");

endmodule

// ===== src/periodic_deadline_timer_table.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// periodic_deadline_timer_table
// Table of periodic timers with init and forward (catch-up) commands.
// ----------------------------------------------------------------------------
// Usage:
//   req_* carries one command per transfer: init loads an entry's deadline
//   from the given time and stores its period; forward adds the stored
//   period until the deadline lies after the given time.
//   rsp_* returns exactly one result per command: status, periods added
//   and the entry's deadline after the operation.
// Timing:
//   one command is worked at a time. A bad index or an init goes from
//   decode straight to its result; a forward first reads its entry and
//   ends there on a zero period, else runs the catch-up loop (one
//   addition per cycle, at most the catch-up limit) before its result.
//   The next request is taken in the cycle after the result is loaded
//   into the output register.
// Reset:
//   synchronous; clears the per-entry valid bits so every timer reads as
//   zero deadline and zero period. No clearing pass is needed.
// Stall:
//   the result waits in the output register while rsp_tready is low; a new
//   request is still taken meanwhile, and its result waits until the held
//   one is transferred.
// ----------------------------------------------------------------------------
module periodic_deadline_timer_table (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   // command[0], timer_index[8:1], period_ns[38:9], now_sec[70:39],
   // now_nsec[100:71], zero fill [103:101]
   input  logic [103:0] req_tdata,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // status[1:0], overshoot[17:2], deadline_sec[49:18], deadline_nsec[79:50]
   output logic [79:0]  rsp_tdata
);

   pdtt_pkg::ctl_type ctl;
   pdtt_pkg::sts_type sts;

   pdtt_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .sts        (sts),
      .ctl        (ctl)
   );

   pdtt_datapath u_datapath (
      .clock      (clock),
      .reset      (reset),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .ctl        (ctl),
      .sts        (sts)
   );

endmodule

// ===== sim/tb_periodic_deadline_timer_table.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_periodic_deadline_timer_table
// Self-checking bench for the periodic deadline timer table. Commands go in
// through the request stream and results are checked field by field against
// a shadow copy of the timer table, advanced here for each accepted command.
// Directed commands cover zero period, bad index, normalization, catch-up
// limit and seconds wrap. Long random traffic follows: mostly init/forward
// sequences close to each deadline, with some noise; every other run adds random gaps and stalls.
// ----------------------------------------------------------------------------
module tb_periodic_deadline_timer_table;

   localparam int LONG_HOLD_CYCLES = 300;
   localparam int FORWARD_BOUND    = 200;

   // command word as carried in req_tdata, command in the lowest bit
   typedef struct packed {
      logic [29:0] now_nsec;
      logic [31:0] now_sec;
      logic [29:0] period_ns;
      logic [7:0]  timer_index;
      logic        command;
   } timer_cmd_type;

   typedef struct packed {
      logic [29:0] deadline_nsec;
      logic [31:0] deadline_sec;
      logic [15:0] overshoot;
      logic [1:0]  status;
   } timer_rsp_type;

   logic         clock = 1'b0;
   logic         reset;
   logic         req_tvalid;
   logic         req_tready;
   // command[0], timer_index[8:1], period_ns[38:9], now_sec[70:39],
   // now_nsec[100:71], zero fill [103:101]
   logic [103:0] req_tdata;
   logic         rsp_tvalid;
   logic         rsp_tready;
   // status[1:0], overshoot[17:2], deadline_sec[49:18], deadline_nsec[79:50]
   logic [79:0]  rsp_tdata;

   logic [31:0]  shadow_sec    [pdtt_pkg::TIMER_COUNT];
   logic [29:0]  shadow_nsec   [pdtt_pkg::TIMER_COUNT];
   logic [29:0]  shadow_period [pdtt_pkg::TIMER_COUNT];

   timer_rsp_type pending_deadlines [$];
   timer_rsp_type rsp_seen;
   timer_rsp_type rsp_due;
   int unsigned   mismatches = 0;

   bit           sender_idles    = 1'b1;
   bit           receiver_stalls = 1'b1;
   bit           hold_request    = 1'b0;

   periodic_deadline_timer_table u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // true when time a is at or after time b, seconds compared unsigned
   function automatic bit not_before(input logic [31:0] a_s, input logic [31:0] a_n,
                                     input logic [31:0] b_s, input logic [31:0] b_n);
      if (a_s != b_s) begin
         return a_s > b_s;
      end
      return a_n >= b_n;
   endfunction

   // result of one command on the shadow table; the table is updated on commit
   function automatic timer_rsp_type advance_timer(input timer_cmd_type c, input bit commit);
      logic [31:0]                 now_s;
      logic [31:0]                 now_n;
      logic [31:0]                 ds;
      logic [31:0]                 dn;
      logic [29:0]                 per;
      logic [pdtt_pkg::ADDR_W-1:0] idx;
      int unsigned                 steps;
      timer_rsp_type               r;
      now_s = c.now_sec;
      now_n = 32'(c.now_nsec);
      if (now_n >= pdtt_pkg::NS_PER_SEC) begin
         now_n -= pdtt_pkg::NS_PER_SEC;
         now_s += 32'd1;
      end
      r = '0;
      if (c.timer_index >= pdtt_pkg::TIMER_COUNT) begin
         r.status = pdtt_pkg::ST_BAD_INDEX;
         return r;
      end
      idx   = c.timer_index[pdtt_pkg::ADDR_W-1:0];
      ds    = shadow_sec[idx];
      dn    = 32'(shadow_nsec[idx]);
      per   = shadow_period[idx];
      steps = 0;
      r.status = pdtt_pkg::ST_OK;
      if (c.command == pdtt_pkg::CMD_INIT) begin
         ds  = now_s;
         dn  = now_n;
         per = c.period_ns;
      end else if (per == '0) begin
         r.status = pdtt_pkg::ST_ZERO_PER;
      end else begin
         while (steps < pdtt_pkg::CATCHUP_LIMIT && not_before(now_s, now_n, ds, dn)) begin
            dn += 32'(per);
            while (dn >= pdtt_pkg::NS_PER_SEC) begin
               dn -= pdtt_pkg::NS_PER_SEC;
               ds += 32'd1;
            end
            steps++;
         end
         if (not_before(now_s, now_n, ds, dn)) begin
            r.status = pdtt_pkg::ST_CATCHUP;
         end
      end
      if (commit) begin
         shadow_sec[idx]    = ds;
         shadow_nsec[idx]   = dn[29:0];
         shadow_period[idx] = per;
      end
      r.overshoot     = 16'(steps);
      r.deadline_sec  = ds;
      r.deadline_nsec = dn[29:0];
      return r;
   endfunction

   function automatic timer_cmd_type make_cmd(input logic cmd, input logic [7:0] idx,
                                              input logic [29:0] per, input logic [31:0] s,
                                              input logic [29:0] n);
      timer_cmd_type c;
      c.command     = cmd;
      c.timer_index = idx;
      c.period_ns   = per;
      c.now_sec     = s;
      c.now_nsec    = n;
      return c;
   endfunction

   function automatic logic [29:0] random_period();
      case ($urandom_range(0, 4))
         0: return 30'($urandom_range(1, 100));
         1: return 30'($urandom_range(1, 1000000));
         2: return 30'($urandom_range(1, 999999999));
         3: return 30'($urandom_range(1000000000, 30'h3FFFFFFF));
         default: return 30'($urandom);
      endcase
   endfunction

   // random traffic must not run into a full catch-up or more than FORWARD_BOUND additions; fall back to time zero
   function automatic timer_cmd_type bound_catchup(input timer_cmd_type c);
      timer_rsp_type peek;
      if (c.command == pdtt_pkg::CMD_FORWARD) begin
         peek = advance_timer(c, 1'b0);
         if (peek.status == pdtt_pkg::ST_CATCHUP || peek.overshoot > FORWARD_BOUND) begin
            c.now_sec  = '0;
            c.now_nsec = '0;
         end
      end
      return c;
   endfunction

   // forward with the current time a few periods past the entry's deadline
   function automatic timer_cmd_type forward_near_deadline(
      input logic [pdtt_pkg::ADDR_W-1:0] idx);
      timer_cmd_type     c;
      longint unsigned   off;
      longint unsigned   ns_sum;
      logic [31:0]       s;
      logic [31:0]       n;
      c = make_cmd(pdtt_pkg::CMD_FORWARD, 8'(idx), 30'($urandom), '0, '0);
      if ($urandom_range(0, 5) == 0) begin
         s = shadow_sec[idx] - 32'($urandom_range(0, 1));
         n = 32'($urandom_range(0, 999999999));
      end else begin
         off    = longint'($urandom_range(0, 7)) * shadow_period[idx]
                  + $urandom_range(0, shadow_period[idx]);
         ns_sum = shadow_nsec[idx] + off % pdtt_pkg::NS_PER_SEC;
         s      = shadow_sec[idx] + 32'(off / pdtt_pkg::NS_PER_SEC)
                  + 32'(ns_sum / pdtt_pkg::NS_PER_SEC);
         n      = 32'(ns_sum % pdtt_pkg::NS_PER_SEC);
      end
      // same instant written with the nanoseconds not yet carried
      if (s != 0 && n <= 32'h3FFFFFFF - pdtt_pkg::NS_PER_SEC && $urandom_range(0, 7) == 0) begin
         s -= 32'd1;
         n += pdtt_pkg::NS_PER_SEC;
      end
      c.now_sec  = s;
      c.now_nsec = n[29:0];
      return bound_catchup(c);
   endfunction

   function automatic int unsigned next_gap();
      if (sender_idles && $urandom_range(0, 3) == 0) begin
         return $urandom_range(1, 6);
      end
      return 0;
   endfunction

   function automatic void check_field(input string name, input logic [31:0] want,
                                       input logic [31:0] got);
      if (want !== got) begin
         $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
         mismatches++;
      end
   endfunction

   // starts and ends at a rising edge; valid stays high after the transfer
   task automatic send_item(input timer_cmd_type c, input int unsigned gap);
      if (gap != 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tdata  <= {3'b000, c};
      req_tvalid <= 1'b1;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      pending_deadlines.push_back(advance_timer(c, 1'b1));
   endtask

   task automatic wait_drained();
      req_tvalid <= 1'b0;
      while (pending_deadlines.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic test_zero_period_and_bad_index();
      send_item(make_cmd(pdtt_pkg::CMD_FORWARD, 8'd0, 30'd5, 32'd7, 30'd7), next_gap());
      send_item(make_cmd(pdtt_pkg::CMD_FORWARD, 8'd8, 30'd1, 32'd1, 30'd1), next_gap());
      send_item(make_cmd(pdtt_pkg::CMD_INIT, 8'd255, 30'h3FFFFFFF, 32'hFFFFFFFF,
                         30'h3FFFFFFF), next_gap());
      send_item(make_cmd(pdtt_pkg::CMD_INIT, 8'd2, 30'd0, 32'd100, 30'd0), next_gap());
      send_item(make_cmd(pdtt_pkg::CMD_FORWARD, 8'd2, 30'd0, 32'd200, 30'd0), next_gap());
      wait_drained();
   endtask

   task automatic test_init_and_forward();
      send_item(make_cmd(pdtt_pkg::CMD_INIT, 8'd7, 30'd999999999, 32'h12345678,
                         30'd999999999), next_gap());
      send_item(make_cmd(pdtt_pkg::CMD_FORWARD, 8'd7, 30'd0, 32'h12345678, 30'd999999999),
                next_gap());
      // deadline already ahead
      send_item(make_cmd(pdtt_pkg::CMD_FORWARD, 8'd7, 30'd0, 32'h12345678, 30'd0),
                next_gap());
      send_item(make_cmd(pdtt_pkg::CMD_FORWARD, 8'd7, 30'd0, 32'h1234567B, 30'd500000000),
                next_gap());
      // nanoseconds and period both above one second
      send_item(make_cmd(pdtt_pkg::CMD_INIT, 8'd1, 30'h3FFFFFFF, 32'd5, 30'h3FFFFFFF),
                next_gap());
      send_item(make_cmd(pdtt_pkg::CMD_FORWARD, 8'd1, 30'd0, 32'd40, 30'd0), next_gap());
      send_item(make_cmd(pdtt_pkg::CMD_INIT, 8'd0, 30'd1, 32'd0, 30'd0), next_gap());
      send_item(make_cmd(pdtt_pkg::CMD_FORWARD, 8'd0, 30'd0, 32'd0, 30'd0), next_gap());
      wait_drained();
   endtask

   task automatic test_catchup_limit();
      // exactly the limit of additions, deadline then just ahead
      send_item(make_cmd(pdtt_pkg::CMD_INIT, 8'd3, 30'd1, 32'd0, 30'd0), next_gap());
      send_item(make_cmd(pdtt_pkg::CMD_FORWARD, 8'd3, 30'd0, 32'd0, 30'd65534), next_gap());
      // deadline wraps past the top second and never catches up
      send_item(make_cmd(pdtt_pkg::CMD_INIT, 8'd5, 30'd100, 32'hFFFFFFFF, 30'd999999990),
                next_gap());
      send_item(make_cmd(pdtt_pkg::CMD_FORWARD, 8'd5, 30'd0, 32'hFFFFFFFF, 30'd999999999),
                next_gap());
      send_item(make_cmd(pdtt_pkg::CMD_FORWARD, 8'd5, 30'd0, 32'd0, 30'd0), next_gap());
      wait_drained();
   endtask

   task automatic test_backpressure();
      int k;
      hold_request = 1'b1;
      send_item(make_cmd(pdtt_pkg::CMD_INIT, 8'd6, 30'd250000, 32'd42, 30'd0), 0);
      for (k = 0; k < 10; k++) begin
         send_item(forward_near_deadline(3'd6), 0);
      end
      wait_drained();
   endtask

   task automatic test_random_traffic(input int unsigned count, input bit idling);
      int unsigned                 k;
      int unsigned                 pick;
      int unsigned                 slot;
      logic [pdtt_pkg::ADDR_W-1:0] idx;
      timer_cmd_type               c;
      sender_idles    = idling;
      receiver_stalls = idling;
      for (k = 0; k < count; k++) begin
         pick = $urandom_range(0, 99);
         slot = $urandom_range(0, pdtt_pkg::TIMER_COUNT - 1);
         idx  = slot[pdtt_pkg::ADDR_W-1:0];
         if (pick < 8) begin
            c = make_cmd(1'($urandom), 8'($urandom_range(pdtt_pkg::TIMER_COUNT, 255)),
                         30'($urandom), $urandom, 30'($urandom));
         end else if (pick < 16) begin
            c = make_cmd(1'($urandom), 8'(idx),
                         ($urandom_range(0, 3) == 0) ? 30'd0 : 30'($urandom),
                         $urandom, 30'($urandom));
            c = bound_catchup(c);
         end else if (pick < 30 || shadow_period[idx] == '0) begin
            c = make_cmd(pdtt_pkg::CMD_INIT, 8'(idx), random_period(), $urandom,
                         30'($urandom_range(0, 999999999)));
         end else begin
            c = forward_near_deadline(idx);
         end
         send_item(c, next_gap());
      end
   endtask

   // receiver side: random stalls and, on request, one long hold-off
   initial begin
      int unsigned held;
      rsp_tready = 1'b0;
      forever begin
         @(posedge clock);
         if (hold_request) begin
            rsp_tready <= 1'b0;
            for (held = 0; held < LONG_HOLD_CYCLES; held++) @(posedge clock);
            hold_request = 1'b0;
            rsp_tready <= 1'b1;
         end else if (receiver_stalls && $urandom_range(0, 5) == 0) begin
            rsp_tready <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clock);
            rsp_tready <= 1'b1;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         rsp_seen = rsp_tdata;
         if (pending_deadlines.size() == 0) begin
            $display("%0t ns: result transfer with none expected, actual %h", $time, rsp_seen);
            mismatches++;
         end else begin
            rsp_due = pending_deadlines.pop_front();
            check_field("status", 32'(rsp_due.status), 32'(rsp_seen.status));
            check_field("overshoot", 32'(rsp_due.overshoot), 32'(rsp_seen.overshoot));
            check_field("deadline_sec", rsp_due.deadline_sec, rsp_seen.deadline_sec);
            check_field("deadline_nsec", 32'(rsp_due.deadline_nsec),
                        32'(rsp_seen.deadline_nsec));
         end
      end
   end

   initial begin
      #20000000;
      $display("[FAIL] regression broken");
      $finish;
   end

   initial begin
      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tdata  = '0;
      for (int i = 0; i < pdtt_pkg::TIMER_COUNT; i++) begin
         shadow_sec[i]    = '0;
         shadow_nsec[i]   = '0;
         shadow_period[i] = '0;
      end
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_zero_period_and_bad_index();
      test_init_and_forward();
      test_catchup_limit();
      test_backpressure();
      test_random_traffic(350, 1'b1);
      test_random_traffic(150, 1'b0);
      test_random_traffic(350, 1'b1);
      test_random_traffic(150, 1'b0);
      wait_drained();

      if (mismatches == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule

// ===== files.f =====
src/pdtt_pkg.sv
src/pdtt_ram.sv
src/pdtt_ctrl.sv
src/pdtt_datapath.sv
src/periodic_deadline_timer_table.sv
sim/tb_periodic_deadline_timer_table.sv
